// File: hdl/bis_pkg.sv
// Package for the bounded integer set store: command and status codes,
// controller states and default sizes. No dependencies.
package bis_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } bis_state_t;

endpackage

// File: hdl/bis_ram.sv
// Element memory: one write port, one registered read port.
// Depends on bis_pkg for the data width.
module bis_ram #(
  parameter int DEPTH = bis_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [bis_pkg::DATA_W-1:0]  wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [bis_pkg::DATA_W-1:0]  rdata
);
  import bis_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/bounded_integer_set_store_unit.sv
// Top level of the bounded integer set store: controller, scan datapath and
// result registers around bis_ram. Depends on bis_pkg and bis_ram.
//
//   channel  | handshake        | payload
//   ---------+------------------+-------------------------------------------
//   command  | start / busy     | command, value
//   result   | done (1 cycle)   | status, was_present, element_count,
//            |                  | is_empty, min_value, max_value
//
// A command is accepted in S_IDLE; an empty set goes straight to S_FINISH.
// Otherwise the scan reads each stored entry once through the single memory
// read port, one per cycle, and compares it as the registered read data
// returns; after the last compare the controller passes through S_FINISH,
// which registers the result strobe. Removal compacts the later entries in the scan.
// Reset (rst, synchronous) empties the set; memory contents are not cleared.
// Results cannot be stalled; busy drops on the cycle the result strobe rises.
module bounded_integer_set_store_unit #(
  parameter int CAPACITY = bis_pkg::CAPACITY_DEF,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         command,
  input  logic signed [bis_pkg::DATA_W-1:0]  value,
  output logic                               done,
  output logic [1:0]                         status,
  output logic                               was_present,
  output logic [CW-1:0]                      element_count,
  output logic                               is_empty,
  output logic signed [bis_pkg::DATA_W-1:0]  min_value,
  output logic signed [bis_pkg::DATA_W-1:0]  max_value
);
  import bis_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  bis_state_t state, state_next;

  logic [CW-1:0]            count;
  logic [1:0]               cmd;
  logic signed [DATA_W-1:0] val;
  logic [CW-1:0]            rd_idx;
  logic                     chk_vld;
  logic [AW-1:0]            chk_idx;
  logic                     found;
  logic                     have_mm;
  logic signed [DATA_W-1:0] mn, mx;

  logic                     issue;
  logic [DATA_W-1:0]        rdata;
  logic signed [DATA_W-1:0] elem;
  logic                     match;
  logic                     we;
  logic [AW-1:0]            waddr;
  logic [DATA_W-1:0]        wdata;

  logic                     ins_new, incl_v;
  logic [1:0]               status_next;
  logic [CW-1:0]            count_next;
  logic signed [DATA_W-1:0] mn_next, mx_next;

  bis_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (issue),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rdata)
  );

  assign busy  = (state != S_IDLE);
  assign elem  = $signed(rdata);
  assign match = chk_vld && (elem == val);

  // next state and scan control
  always_comb begin
    state_next = state;
    issue      = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (count == '0) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        issue = (rd_idx < count);
        if (!issue && !chk_vld) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // command resolution at the end of the scan
  always_comb begin
    ins_new     = (cmd == CMD_INSERT) && !found && (count < CW'(CAPACITY));
    incl_v      = (found && (cmd != CMD_REMOVE)) || ins_new;
    status_next = ST_DONE;
    count_next  = count;
    case (cmd)
      CMD_INSERT: begin
        if (found) begin
          status_next = ST_PRESENT;
        end else if (!ins_new) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (!found) begin
          status_next = ST_ABSENT;
        end else begin
          count_next = count - 1'b1;
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
    if (have_mm) begin
      mn_next = (incl_v && (val < mn)) ? val : mn;
      mx_next = (incl_v && (val > mx)) ? val : mx;
    end else if (incl_v) begin
      mn_next = val;
      mx_next = val;
    end else begin
      mn_next = '0;
      mx_next = '0;
    end
  end

  // memory write: compaction shift during scan, append on insert
  always_comb begin
    we    = 1'b0;
    waddr = chk_idx - 1'b1;
    wdata = rdata;
    if (state == S_SCAN) begin
      we = chk_vld && found && (cmd == CMD_REMOVE);
    end else if (state == S_FINISH) begin
      we    = ins_new;
      waddr = count[AW-1:0];
      wdata = val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      done    <= 1'b0;
      chk_vld <= 1'b0;
      found   <= 1'b0;
      have_mm <= 1'b0;
      rd_idx  <= '0;
    end else begin
      state   <= state_next;
      done    <= (state == S_FINISH);
      chk_vld <= issue;
      if (state == S_IDLE && start) begin
        found   <= 1'b0;
        have_mm <= 1'b0;
        rd_idx  <= '0;
      end else begin
        if (issue) begin
          rd_idx <= rd_idx + 1'b1;
        end
        if (match) begin
          found <= 1'b1;
        end else if (chk_vld) begin
          have_mm <= 1'b1;
        end
      end
      if (state == S_FINISH) begin
        count <= count_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd <= command;
      val <= value;
    end
    if (issue) begin
      chk_idx <= rd_idx[AW-1:0];
    end
    if (chk_vld && !match) begin
      if (!have_mm || elem < mn) begin
        mn <= elem;
      end
      if (!have_mm || elem > mx) begin
        mx <= elem;
      end
    end
    if (state == S_FINISH) begin
      status        <= status_next;
      was_present   <= found;
      element_count <= count_next;
      is_empty      <= (count_next == '0);
      min_value     <= mn_next;
      max_value     <= mx_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_FINISH)
    else $error("result strobe without finish step");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && is_empty) |-> (min_value == '0 && max_value == '0 &&
                            element_count == '0))
    else $error("empty result with nonzero fields");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (done && !is_empty) |-> (min_value <= max_value))
    else $error("minimum above maximum");

endmodule

// File: bench/set_store_checker.sv
// Checker for the bounded integer set store: watches the command and result
// channels, keeps its own copy of the set, and compares every result beat.
// Depends on bis_pkg.
module set_store_checker #(
  parameter int CAP = bis_pkg::CAPACITY_DEF,
  parameter int CW  = $clog2(CAP + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic [1:0]                        command,
  input  logic signed [bis_pkg::DATA_W-1:0] value,
  input  logic                              done,
  input  logic [1:0]                        status,
  input  logic                              was_present,
  input  logic [CW-1:0]                     element_count,
  input  logic                              is_empty,
  input  logic signed [bis_pkg::DATA_W-1:0] min_value,
  input  logic signed [bis_pkg::DATA_W-1:0] max_value,
  output int                                pending,
  output int                                mismatches,
  output int                                compared
);
  import bis_pkg::*;

  typedef struct {
    logic [1:0]               status;
    logic                     was_present;
    logic [CW-1:0]            count;
    logic                     is_empty;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
  } set_view_t;

  logic [DATA_W-1:0] members [CAP];
  int                member_count = 0;
  set_view_t         expected_q [$];
  int                fail_total = 0;
  int                seen_total = 0;

  // Applies one command to the local set and returns the view it should report.
  function automatic set_view_t apply_command(input logic [1:0] cmd,
                                              input logic [DATA_W-1:0] v);
    set_view_t                r;
    int                       slot;
    int                       i;
    logic signed [DATA_W-1:0] e;
    slot = -1;
    for (i = 0; i < member_count; i++) begin
      if (slot < 0 && members[i] == v) slot = i;
    end
    r.status      = ST_DONE;
    r.was_present = (slot >= 0);
    case (cmd)
      CMD_INSERT: begin
        if (slot >= 0) begin
          r.status = ST_PRESENT;
        end else if (member_count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          members[member_count] = v;
          member_count++;
        end
      end
      CMD_REMOVE: begin
        if (slot < 0) begin
          r.status = ST_ABSENT;
        end else begin
          // later entries slide down, order kept
          for (i = slot; i < member_count - 1; i++) members[i] = members[i + 1];
          member_count--;
        end
      end
      default: ;  // query and the unused code change nothing
    endcase
    r.count    = CW'(member_count);
    r.is_empty = (member_count == 0);
    r.lo       = '0;
    r.hi       = '0;
    if (member_count > 0) begin
      r.lo = members[0];
      r.hi = members[0];
      for (i = 1; i < member_count; i++) begin
        e = members[i];
        if (e < r.lo) r.lo = e;
        if (e > r.hi) r.hi = e;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    set_view_t want;
    if (rst) begin
      expected_q.delete();
      member_count = 0;
      pending <= 0;
    end else begin
      // compare first so a beat leaving and a command arriving on one edge pair up right
      if (done) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no command outstanding");
          fail_total++;
        end else begin
          want = expected_q.pop_front();
          seen_total++;
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            fail_total++;
          end
          if (was_present !== want.was_present) begin
            $error("was_present: expected %0d, actual %0d", want.was_present, was_present);
            fail_total++;
          end
          if (element_count !== want.count) begin
            $error("element_count: expected %0d, actual %0d", want.count, element_count);
            fail_total++;
          end
          if (is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, actual %0d", want.is_empty, is_empty);
            fail_total++;
          end
          if (min_value !== want.lo) begin
            $error("min_value: expected %0d, actual %0d", want.lo, min_value);
            fail_total++;
          end
          if (max_value !== want.hi) begin
            $error("max_value: expected %0d, actual %0d", want.hi, max_value);
            fail_total++;
          end
        end
      end
      if (start && !busy) expected_q.push_back(apply_command(command, value));
      pending <= expected_q.size();
    end
    mismatches <= fail_total;
    compared   <= seen_total;
  end

endmodule

// File: bench/tb.sv
// Testbench top for the bounded integer set store: clock, reset, directed and
// pool-driven random commands with bursty pacing, and the verdict.
// Depends on bis_pkg, bounded_integer_set_store_unit and set_store_checker.
module tb;
  import bis_pkg::*;

  localparam int          CAP        = CAPACITY_DEF;
  localparam int          CW         = $clog2(CAP + 1);
  localparam int          POOL_N     = 80;
  localparam int          ROUNDS     = 13;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  localparam logic [31:0] VAL_MIN    = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX    = 32'h7FFF_FFFF;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [1:0]               command;
  logic signed [DATA_W-1:0] value;
  logic                     done;
  logic [1:0]               status;
  logic                     was_present;
  logic [CW-1:0]            element_count;
  logic                     is_empty;
  logic signed [DATA_W-1:0] min_value;
  logic signed [DATA_W-1:0] max_value;

  int pending;
  int mismatches;
  int compared;

  logic [31:0] pool [POOL_N];
  bit          held [POOL_N];
  int          stocked;
  int          burst_left;
  int          n_ins;
  int          n_rem;
  int          n_qry;

  bounded_integer_set_store_unit #(.CAPACITY(CAP)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command), .value(value),
    .done(done), .status(status), .was_present(was_present),
    .element_count(element_count), .is_empty(is_empty),
    .min_value(min_value), .max_value(max_value)
  );

  set_store_checker #(.CAP(CAP), .CW(CW)) u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command), .value(value),
    .done(done), .status(status), .was_present(was_present),
    .element_count(element_count), .is_empty(is_empty),
    .min_value(min_value), .max_value(max_value),
    .pending(pending), .mismatches(mismatches), .compared(compared)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // Holds a command beat until accepted, then maybe closes the burst with a gap.
  task automatic send(input logic [1:0] cmd, input logic [31:0] v);
    case (cmd)
      CMD_INSERT: n_ins++;
      CMD_REMOVE: n_rem++;
      default:    n_qry++;
    endcase
    start   <= 1'b1;
    command <= cmd;
    value   <= v;
    do @(posedge clk); while (busy);
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 19))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return 32'h0;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // New pool value, distinct from every other pool entry.
  function automatic logic [31:0] fresh_word(input int slot);
    logic [31:0] w;
    bit          clash;
    do begin
      w     = rand_word();
      clash = 1'b0;
      for (int j = 0; j < POOL_N; j++) if (j != slot && pool[j] == w) clash = 1'b1;
    end while (clash);
    return w;
  endfunction

  // Random pool index below lim whose held flag matches, or -1.
  function automatic int find_pool(input bit want_held, input int lim);
    int s;
    int idx;
    s = $urandom_range(0, lim - 1);
    for (int k = 0; k < lim; k++) begin
      idx = (s + k) % lim;
      if (held[idx] == want_held) return idx;
    end
    return -1;
  endfunction

  initial begin : stimulus
    int psize;
    int ins_pct;
    int ins_lim;
    int n_items;
    int roll;
    int idx;
    rst        = 1'b1;
    start      = 1'b0;
    command    = CMD_QUERY;
    value      = '0;
    stocked    = 0;
    burst_left = 5;
    n_ins      = 0;
    n_rem      = 0;
    n_qry      = 0;
    for (int i = 0; i < POOL_N; i++) begin
      pool[i] = 32'h0;
      held[i] = 1'b0;
    end
    for (int i = 0; i < POOL_N; i++) pool[i] = fresh_word(i);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty set, extremes, duplicates, unused code, removal at first, middle and last position
    send(CMD_QUERY,  32'd5);
    send(CMD_REMOVE, 32'd5);
    send(CMD_UNUSED, 32'd0);
    send(CMD_INSERT, VAL_MIN);
    send(CMD_INSERT, VAL_MAX);
    send(CMD_INSERT, 32'd0);
    send(CMD_INSERT, 32'hFFFF_FFFF);
    send(CMD_INSERT, 32'd1);
    send(CMD_INSERT, VAL_MAX);
    send(CMD_QUERY,  32'hFFFF_FFFF);
    send(CMD_QUERY,  32'd2);
    send(CMD_UNUSED, VAL_MIN);
    send(CMD_REMOVE, 32'd0);
    send(CMD_REMOVE, 32'd0);
    send(CMD_REMOVE, VAL_MIN);
    send(CMD_REMOVE, 32'd1);
    send(CMD_REMOVE, VAL_MAX);
    send(CMD_REMOVE, 32'hFFFF_FFFF);
    send(CMD_INSERT, 32'h5555_5555);
    send(CMD_INSERT, 32'hAAAA_AAAA);
    send(CMD_REMOVE, 32'h5555_5555);
    send(CMD_REMOVE, 32'hAAAA_AAAA);
    drain();

    // random mixes: first one is insert-heavy to fill the store to capacity, later ones vary
    for (int r = 0; r < ROUNDS; r++) begin
      psize   = (r == 0) ? POOL_N : $urandom_range(3, POOL_N);
      ins_pct = (r == 0) ? 90 : $urandom_range(10, 90);
      n_items = (r == 0) ? 180 : 95;
      ins_lim = 5 + ins_pct * 80 / 100;
      for (int i = 0; i < POOL_N; i++) if (!held[i]) pool[i] = fresh_word(i);
      for (int k = 0; k < n_items; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          send(CMD_UNUSED, rand_word());
        end else if (roll < ins_lim) begin
          idx = ($urandom_range(0, 99) < 75) ? find_pool(1'b0, psize) : -1;
          if (idx < 0) idx = $urandom_range(0, psize - 1);
          send(CMD_INSERT, pool[idx]);
          if (!held[idx] && stocked < CAP) begin
            held[idx] = 1'b1;
            stocked++;
          end
        end else if (roll < 88) begin
          idx = ($urandom_range(0, 99) < 80) ? find_pool(1'b1, POOL_N) : -1;
          if (idx < 0) idx = $urandom_range(0, psize - 1);
          send(CMD_REMOVE, pool[idx]);
          if (held[idx]) begin
            held[idx] = 1'b0;
            stocked--;
          end
        end else begin
          send(CMD_QUERY, $urandom_range(0, 1) ? rand_word()
                                               : pool[$urandom_range(0, POOL_N - 1)]);
        end
      end
      if (r == 0 || $urandom_range(0, 2) == 0) drain();
    end

    drain();
    repeat (80) @(posedge clk);
    $display("Sent %0d commands: %0d inserts, %0d removes, %0d queries or unused code.",
             n_ins + n_rem + n_qry, n_ins, n_rem, n_qry);
    $display("Compared %0d result beats across %0d value mixes, store filled to capacity.",
             compared, ROUNDS);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
